>>> hdl/mdts_pkg.sv
// Shared types and constants for the minimum degree sum triangle search block.
package mdts_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = VW + 1;
  localparam int unsigned DW = 6;
  localparam int unsigned SW = 8;
  localparam logic [DW-1:0] DEGREE_MAX = '1;
  localparam logic [SW-1:0] DEGREE_OFFSET = SW'(6);

  typedef struct packed {
    logic          edge_present;
    logic [VW-1:0] first_vertex;
    logic [VW-1:0] second_vertex;
    logic          last_edge;
  } in_item_t;

  typedef struct packed {
    logic          triangle_found;
    logic [SW-1:0] recognition_sum;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EDGE_A,
    OP_EDGE_B,
    OP_SRCH_INIT,
    OP_RD_I,
    OP_LAT_I,
    OP_RD_J,
    OP_LAT_J,
    OP_NEXT_J,
    OP_NEXT_I,
    OP_RD_K,
    OP_NEXT_K,
    OP_LAT_K,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic edge_ok;
    logic dup;
    logic last;
    logic i_end;
    logic j_end;
    logic k_end;
    logic bit_ij;
    logic bit_k;
  } dp_status_t;

endpackage

>>> hdl/mdts_datapath.sv
// Datapath: adjacency and degree store, search counters and the running minimum.
module mdts_datapath
  import mdts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  op_t        op,
  input  in_item_t   in_data,
  output dp_status_t status,
  output out_item_t  result
);

  localparam int unsigned RW = MAX_VERTICES + DW;

  logic [RW-1:0]           mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid_r, row_valid_nxt;
  logic [RW-1:0]           rd_data_r;
  logic                    rd_valid_r;
  logic [VW-1:0]           rd_addr;
  logic                    rd_en;
  logic [VW-1:0]           wr_addr;
  logic [RW-1:0]           wr_data;
  logic                    wr_en;

  logic [VW-1:0]           a_r, b_r;
  logic                    edge_ok_r, last_r;
  logic [CW-1:0]           i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic [MAX_VERTICES-1:0] row_i_r, row_j_r;
  logic [DW-1:0]           deg_i_r, deg_j_r;
  logic                    found_r, found_nxt;
  logic [SW-1:0]           best_r, best_nxt;

  logic [MAX_VERTICES-1:0] rd_adj;
  logic [DW-1:0]           rd_deg, rd_deg_inc;
  logic [SW-1:0]           sum;

  assign rd_adj     = rd_valid_r ? rd_data_r[MAX_VERTICES-1:0] : '0;
  assign rd_deg     = rd_valid_r ? rd_data_r[RW-1:MAX_VERTICES] : '0;
  assign rd_deg_inc = (rd_deg == DEGREE_MAX) ? rd_deg : rd_deg + DW'(1);
  assign sum = SW'(deg_i_r) + SW'(deg_j_r) + SW'(rd_deg);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = a_r;
    wr_en = 1'b0;
    wr_addr = a_r;
    wr_data = {rd_deg_inc, rd_adj | (MAX_VERTICES'(1) << b_r)};
    row_valid_nxt = row_valid_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    found_nxt = found_r;
    best_nxt = best_r;
    case (op)
      OP_LOAD: begin
        rd_en = 1'b1;
        rd_addr = in_data.first_vertex;
      end
      OP_EDGE_A: begin
        wr_en = 1'b1;
        row_valid_nxt[a_r] = 1'b1;
        rd_en = 1'b1;
        rd_addr = b_r;
      end
      OP_EDGE_B: begin
        wr_en = 1'b1;
        wr_addr = b_r;
        wr_data = {rd_deg_inc, rd_adj | (MAX_VERTICES'(1) << a_r)};
        row_valid_nxt[b_r] = 1'b1;
      end
      OP_SRCH_INIT: begin
        i_nxt = '0;
        found_nxt = 1'b0;
        best_nxt = '0;
      end
      OP_RD_I: begin
        rd_en = 1'b1;
        rd_addr = i_r[VW-1:0];
      end
      OP_LAT_I: j_nxt = i_r + CW'(1);
      OP_RD_J: begin
        rd_en = 1'b1;
        rd_addr = j_r[VW-1:0];
      end
      OP_LAT_J: k_nxt = j_r + CW'(1);
      OP_NEXT_J: j_nxt = j_r + CW'(1);
      OP_NEXT_I: i_nxt = i_r + CW'(1);
      OP_RD_K: begin
        rd_en = 1'b1;
        rd_addr = k_r[VW-1:0];
      end
      OP_NEXT_K: k_nxt = k_r + CW'(1);
      OP_LAT_K: begin
        k_nxt = k_r + CW'(1);
        if (!found_r || sum < best_r) begin
          found_nxt = 1'b1;
          best_nxt = sum;
        end
      end
      OP_CLEAR: row_valid_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_valid_r <= row_valid_r[rd_addr];
    end
    if (op == OP_LOAD) begin
      a_r <= in_data.first_vertex;
      b_r <= in_data.second_vertex;
      edge_ok_r <= in_data.edge_present &&
                   (in_data.first_vertex != in_data.second_vertex);
      last_r <= in_data.last_edge;
    end
    if (op == OP_LAT_I) begin
      row_i_r <= rd_adj;
      deg_i_r <= rd_deg;
    end
    if (op == OP_LAT_J) begin
      row_j_r <= rd_adj;
      deg_j_r <= rd_deg;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    best_r <= best_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      found_r <= 1'b0;
    end else begin
      row_valid_r <= row_valid_nxt;
      found_r <= found_nxt;
    end
  end

  always_comb begin
    status.edge_ok = edge_ok_r;
    status.dup     = rd_adj[b_r];
    status.last    = last_r;
    status.i_end   = (i_r >= CW'(MAX_VERTICES));
    status.j_end   = (j_r >= CW'(MAX_VERTICES));
    status.k_end   = (k_r >= CW'(MAX_VERTICES));
    status.bit_ij  = row_i_r[j_r[VW-1:0]];
    status.bit_k   = row_i_r[k_r[VW-1:0]] & row_j_r[k_r[VW-1:0]];
  end

  assign result.triangle_found = found_r;
  assign result.recognition_sum = (found_r && best_r >= DEGREE_OFFSET) ?
                                  best_r - DEGREE_OFFSET : '0;

endmodule

>>> hdl/mdts_ctrl.sv
// Controller: sequences edge loading, the triangle search and result delivery.
module mdts_ctrl
  import mdts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output op_t        op
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_EA    = 12'b000000000010,
    ST_EB    = 12'b000000000100,
    ST_SINIT = 12'b000000001000,
    ST_RI    = 12'b000000010000,
    ST_WI    = 12'b000000100000,
    ST_RJ    = 12'b000001000000,
    ST_WJ    = 12'b000010000000,
    ST_RK    = 12'b000100000000,
    ST_WK    = 12'b001000000000,
    ST_OUT   = 12'b010000000000,
    ST_SPARE = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    op = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          state_nxt = ST_EA;
        end
      end
      ST_EA: begin
        if (status.edge_ok && !status.dup) begin
          op = OP_EDGE_A;
          state_nxt = ST_EB;
        end else begin
          state_nxt = status.last ? ST_SINIT : ST_IDLE;
        end
      end
      ST_EB: begin
        op = OP_EDGE_B;
        state_nxt = status.last ? ST_SINIT : ST_IDLE;
      end
      ST_SINIT: begin
        op = OP_SRCH_INIT;
        state_nxt = ST_RI;
      end
      ST_RI: begin
        if (status.i_end) begin
          state_nxt = ST_OUT;
        end else begin
          op = OP_RD_I;
          state_nxt = ST_WI;
        end
      end
      ST_WI: begin
        op = OP_LAT_I;
        state_nxt = ST_RJ;
      end
      ST_RJ: begin
        if (status.j_end) begin
          op = OP_NEXT_I;
          state_nxt = ST_RI;
        end else if (!status.bit_ij) begin
          op = OP_NEXT_J;
        end else begin
          op = OP_RD_J;
          state_nxt = ST_WJ;
        end
      end
      ST_WJ: begin
        op = OP_LAT_J;
        state_nxt = ST_RK;
      end
      ST_RK: begin
        if (status.k_end) begin
          op = OP_NEXT_J;
          state_nxt = ST_RJ;
        end else if (!status.bit_k) begin
          op = OP_NEXT_K;
        end else begin
          op = OP_RD_K;
          state_nxt = ST_WK;
        end
      end
      ST_WK: begin
        op = OP_LAT_K;
        state_nxt = ST_RK;
      end
      ST_OUT: begin
        if (out_ready) begin
          op = OP_CLEAR;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/min_degree_triangle_search_top.sv
// A request passes idle, edge A and, for a new edge, edge B; one marked last adds the search.
// Search: for each i, read row i; for each j > i adjacent to i, read row j; for each k > j
// adjacent to both, read row k and keep the least degree sum, all over one read port.
// Throughput: one request at a time; ready is high only while the controller is idle.
// Reset: synchronous active-low rst_n clears the controller and all row valid bits at once,
// so the graph store reads as empty immediately; it is cleared the same way after each result.
module min_degree_triangle_search_top
  import mdts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  op_t        op;
  dp_status_t status;

  mdts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  mdts_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (op),
    .in_data (in_data),
    .status  (status),
    .result  (out_data)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels active together");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("block not idle after result delivery");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.triangle_found) |-> (out_data.recognition_sum == '0))
    else $error("nonzero sum without a triangle");

endmodule
